[rtl/tridiagonal_system_solver_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tridiagonal system solver checks.
// ----------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_MACROS_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and Q16.16 helpers of the tridiagonal system solver.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int unsigned MaxRowsDefault = 64;
  localparam int unsigned DivSteps       = 48;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusFirstZero = 2'd1;
  localparam logic [1:0] StatusLaterZero = 2'd2;
  localparam logic [1:0] StatusTooMany   = 2'd3;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_ERR3,
    OP_COUNT,
    OP_ERR1,
    OP_FIRST,
    OP_RDG,
    OP_MULG,
    OP_BET,
    OP_NUM,
    OP_WRU,
    OP_WRG,
    OP_EMIT_ERR,
    OP_BRD0,
    OP_EMIT0,
    OP_BRD,
    OP_BMUL,
    OP_BEMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic err_nz;
    logic first;
    logic b_zero;
    logic bet_zero;
    logic last;
    logic next_ok;
    logic i_zero;
    logic div_busy;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > $signed(48'h0000_7fff_ffff)) begin
      r = 32'sh7fff_ffff;
    end else if (v < $signed(48'hffff_8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Product already formed: divide by 2^16 toward zero, then saturate.
  function automatic logic signed [31:0] qmul_fix(input logic signed [63:0] p);
    logic signed [47:0] t;
    t = p[63:16];
    if (p[63] && (p[15:0] != 16'd0)) begin
      t = t + 48'sd1;
    end
    return sat48(t);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = {x[31], x} - {y[31], y};
    if (d[32] != d[31]) begin
      r = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/tss_ram.sv]
// ----------------------------------------------------------------------------
// tss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/tss_div.sv]
// ----------------------------------------------------------------------------
// tss_div
// Q16.16 divider: (x * 2^16) / y toward zero, saturated, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] y_i,
  output logic                    busy_o,
  output logic signed [31:0]      q_o
);
  import tss_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     rem_q;
  logic [47:0]     quo_q;
  logic [31:0]     dvs_q;
  logic            neg_q;

  logic [31:0] x_mag, y_mag;
  logic [32:0] shifted;
  logic        fits;

  assign x_mag   = x_i[31] ? (~x_i + 32'd1) : x_i;
  assign y_mag   = y_i[31] ? (~y_i + 32'd1) : y_i;
  assign shifted = {rem_q, quo_q[47]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= {x_mag, 16'd0};
      dvs_q <= y_mag;
      neg_q <= x_i[31] ^ y_i[31];
    end else if (busy_q) begin
      rem_q <= fits ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
      quo_q <= {quo_q[46:0], fits};
    end
  end

  always_comb begin
    if (neg_q) begin
      q_o = (quo_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : 32'(~quo_q + 48'd1);
    end else begin
      q_o = (quo_q > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : quo_q[31:0];
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

[rtl/tss_datapath.sv]
// ----------------------------------------------------------------------------
// tss_datapath
// Row registers, coefficient stores, multiplier, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_datapath #(
  parameter int unsigned MaxRows = tss_pkg::MaxRowsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tss_pkg::cmd_t      cmd_i,
  output tss_pkg::status_t        status_o,
  input  wire logic signed [31:0] sub_diag_i,
  input  wire logic signed [31:0] main_diag_i,
  input  wire logic signed [31:0] super_diag_i,
  input  wire logic signed [31:0] rhs_i,
  input  wire logic               last_row_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      solution_o,
  output logic [5:0]              row_index_o,
  output logic [1:0]              status_o_code,
  output logic                    last_result_o
);
  import tss_pkg::*;

  localparam int unsigned AW = $clog2(MaxRows);
  localparam int unsigned CW = $clog2(MaxRows + 1);

  op_e op;
  assign op = cmd_i.op;

  logic signed [31:0] a_q, b_q, c_q, r_q;
  logic               last_q;
  logic [CW-1:0]      j_q, rows_q;
  logic [1:0]         err_q;
  logic signed [31:0] pivot_q, uprev_q, unext_q;
  logic signed [63:0] prod_q;
  logic [AW-1:0]      i_q;
  logic               out_valid_q;

  logic [CW:0]        jp1;
  logic [AW-1:0]      jaddr, jp1addr;
  logic signed [31:0] qm, bet, num, bval;
  logic signed [31:0] mul_x, mul_y;
  logic               out_free, clear_run;

  logic               div_start, div_busy;
  logic signed [31:0] div_x, div_y, div_q;

  logic          g_wr, g_rd, u_wr, u_rd;
  logic [AW-1:0] g_rd_addr, u_rd_addr;
  logic [31:0]   g_data, u_data;

  assign jp1     = {1'b0, j_q} + 1'b1;
  assign jaddr   = j_q[AW-1:0];
  assign jp1addr = jp1[AW-1:0];
  assign qm      = qmul_fix(prod_q);
  assign bet     = qsub(b_q, qm);
  assign num     = qsub(r_q, qm);
  assign bval    = qsub($signed(u_data), qm);
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.full     = j_q >= CW'(MaxRows);
  assign status_o.err_nz   = err_q != StatusOk;
  assign status_o.first    = j_q == '0;
  assign status_o.b_zero   = b_q == '0;
  assign status_o.bet_zero = bet == '0;
  assign status_o.last     = last_q;
  assign status_o.next_ok  = jp1 < (CW + 1)'(MaxRows);
  assign status_o.i_zero   = i_q == '0;
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = out_free;

  // Multiplier operand select.
  always_comb begin
    unique case (op)
      OP_MULG: begin mul_x = a_q;              mul_y = $signed(g_data); end
      OP_BET:  begin mul_x = a_q;              mul_y = uprev_q;         end
      default: begin mul_x = $signed(g_data);  mul_y = unext_q;         end
    endcase
  end

  // Divider operand select.
  always_comb begin
    div_start = 1'b0;
    div_x     = c_q;
    div_y     = pivot_q;
    unique case (op)
      OP_FIRST: begin div_start = 1'b1; div_x = r_q; div_y = b_q; end
      OP_NUM:   begin div_start = 1'b1; div_x = num; end
      OP_WRU:   div_start = !last_q && status_o.next_ok;
      default:  ;
    endcase
  end

  assign g_wr      = op == OP_WRG;
  assign u_wr      = op == OP_WRU;
  assign g_rd      = (op == OP_RDG) || (op == OP_BRD);
  assign u_rd      = (op == OP_RDG) || (op == OP_BRD0) || (op == OP_BRD);
  assign g_rd_addr = (op == OP_RDG) ? jaddr : i_q;
  always_comb begin
    unique case (op)
      OP_RDG:  u_rd_addr = jaddr - 1'b1;
      OP_BRD0: u_rd_addr = jaddr;
      default: u_rd_addr = i_q - 1'b1;
    endcase
  end

  assign clear_run = (op == OP_EMIT_ERR) ||
                     (((op == OP_EMIT0) || (op == OP_BEMIT)) && (i_q == '0));

  // Run control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= '0;
      err_q       <= StatusOk;
      pivot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear_run) begin
        rows_q  <= '0;
        err_q   <= StatusOk;
        pivot_q <= '0;
      end else begin
        unique case (op)
          OP_ERR3:  err_q <= StatusTooMany;
          OP_COUNT: rows_q <= rows_q + 1'b1;
          OP_ERR1: begin
            rows_q <= rows_q + 1'b1;
            err_q  <= StatusFirstZero;
          end
          OP_FIRST: begin
            rows_q  <= rows_q + 1'b1;
            pivot_q <= b_q;
          end
          OP_RDG:   rows_q <= rows_q + 1'b1;
          OP_BET: begin
            if (bet == '0) begin
              err_q <= StatusLaterZero;
            end else begin
              pivot_q <= bet;
            end
          end
          default: ;
        endcase
      end
      if ((op == OP_EMIT_ERR) || (op == OP_EMIT0) || (op == OP_BEMIT)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (op == OP_LATCH) begin
      a_q    <= sub_diag_i;
      b_q    <= main_diag_i;
      c_q    <= super_diag_i;
      r_q    <= rhs_i;
      last_q <= last_row_i;
      j_q    <= rows_q;
    end
    if ((op == OP_MULG) || (op == OP_BET) || (op == OP_BMUL)) begin
      prod_q <= mul_x * mul_y;
    end
    if (op == OP_MULG) begin
      uprev_q <= $signed(u_data);
    end
    if (op == OP_BRD0) begin
      i_q <= jaddr;
    end else if (op == OP_BRD) begin
      i_q <= i_q - 1'b1;
    end
    unique case (op)
      OP_EMIT_ERR: begin
        solution_o    <= '0;
        row_index_o   <= '0;
        status_o_code <= err_q;
        last_result_o <= 1'b1;
      end
      OP_EMIT0: begin
        solution_o    <= $signed(u_data);
        row_index_o   <= 6'(i_q);
        status_o_code <= StatusOk;
        last_result_o <= i_q == '0;
        unext_q       <= $signed(u_data);
      end
      OP_BEMIT: begin
        solution_o    <= bval;
        row_index_o   <= 6'(i_q);
        status_o_code <= StatusOk;
        last_result_o <= i_q == '0;
        unext_q       <= bval;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  tss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .y_i     (div_y),
    .busy_o  (div_busy),
    .q_o     (div_q)
  );

  tss_ram #(.Width(32), .Depth(MaxRows)) u_gamma_ram (
    .clk_i     (clk_i),
    .wr_en_i   (g_wr),
    .wr_addr_i (jp1addr),
    .wr_data_i (div_q),
    .rd_en_i   (g_rd),
    .rd_addr_i (g_rd_addr),
    .rd_data_o (g_data)
  );

  tss_ram #(.Width(32), .Depth(MaxRows)) u_usol_ram (
    .clk_i     (clk_i),
    .wr_en_i   (u_wr),
    .wr_addr_i (jaddr),
    .wr_data_i (div_q),
    .rd_en_i   (u_rd),
    .rd_addr_i (u_rd_addr),
    .rd_data_o (u_data)
  );

endmodule

`default_nettype wire

[rtl/tss_ctrl.sv]
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: forward sweep per row, error handling, back substitution.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tss_pkg::status_t status_i,
  output tss_pkg::cmd_t         cmd_o
);
  import tss_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CHECK = 15'b000000000000010,
    S_MULG  = 15'b000000000000100,
    S_BET   = 15'b000000000001000,
    S_NUM   = 15'b000000000010000,
    S_DIVU  = 15'b000000000100000,
    S_WRU   = 15'b000000001000000,
    S_DIVG  = 15'b000000010000000,
    S_WRG   = 15'b000000100000000,
    S_FIN   = 15'b000001000000000,
    S_BRD0  = 15'b000010000000000,
    S_EMIT0 = 15'b000100000000000,
    S_BRD   = 15'b001000000000000,
    S_BMUL  = 15'b010000000000000,
    S_BEMIT = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  op_e    op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LATCH;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (status_i.full) begin
          op      = OP_ERR3;
          state_d = S_FIN;
        end else if (status_i.err_nz) begin
          op      = OP_COUNT;
          state_d = S_FIN;
        end else if (status_i.first && status_i.b_zero) begin
          op      = OP_ERR1;
          state_d = S_FIN;
        end else if (status_i.first) begin
          op      = OP_FIRST;
          state_d = S_DIVU;
        end else begin
          op      = OP_RDG;
          state_d = S_MULG;
        end
      end
      S_MULG: begin
        op      = OP_MULG;
        state_d = S_BET;
      end
      S_BET: begin
        op      = OP_BET;
        state_d = status_i.bet_zero ? S_FIN : S_NUM;
      end
      S_NUM: begin
        op      = OP_NUM;
        state_d = S_DIVU;
      end
      S_DIVU: begin
        if (!status_i.div_busy) state_d = S_WRU;
      end
      S_WRU: begin
        op = OP_WRU;
        priority if (status_i.last) state_d = S_BRD0;
        else if (status_i.next_ok)  state_d = S_DIVG;
        else                        state_d = S_IDLE;
      end
      S_DIVG: begin
        if (!status_i.div_busy) state_d = S_WRG;
      end
      S_WRG: begin
        op      = OP_WRG;
        state_d = S_IDLE;
      end
      S_FIN: begin
        if (!status_i.last) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          op      = OP_EMIT_ERR;
          state_d = S_IDLE;
        end
      end
      S_BRD0: begin
        op      = OP_BRD0;
        state_d = S_EMIT0;
      end
      S_EMIT0: begin
        if (status_i.out_free) begin
          op      = OP_EMIT0;
          state_d = status_i.i_zero ? S_IDLE : S_BRD;
        end
      end
      S_BRD: begin
        op      = OP_BRD;
        state_d = S_BMUL;
      end
      S_BMUL: begin
        op      = OP_BMUL;
        state_d = S_BEMIT;
      end
      S_BEMIT: begin
        if (status_i.out_free) begin
          op      = OP_BEMIT;
          state_d = status_i.i_zero ? S_IDLE : S_BRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;
  assign cmd_o.op   = op;

endmodule

`default_nettype wire

[rtl/tridiagonal_system_solver.sv]
// ----------------------------------------------------------------------------
// tridiagonal_system_solver
// Thomas-algorithm solver for tridiagonal systems in signed Q16.16.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  in      | in  | in_valid_i / in_stall_o | sub/main/super diag, rhs, last
//  out     | out | out_valid_o/out_stall_i | solution, row_index, status, last
//
//  The 48-step bit-serial divider sets the time per row (two divides per row,
//  one on the last row). Back substitution emits one result per read, multiply
//  and emit step, from the last row down to row 0. A row swallowed after an
//  error passes S_CHECK and S_FIN only; a row that hits a zero later pivot
//  stops at S_BET. Reset clears run state only; the coefficient RAMs need no
//  clearing pass. A stalled out holds the sequencer at the next emit; the next
//  row is taken once the last result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tridiagonal_system_solver #(
  parameter int unsigned MaxRows = tss_pkg::MaxRowsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] sub_diag_i,
  input  wire logic signed [31:0] main_diag_i,
  input  wire logic signed [31:0] super_diag_i,
  input  wire logic signed [31:0] rhs_i,
  input  wire logic               last_row_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      solution_o,
  output logic [5:0]              row_index_o,
  output logic [1:0]              status_o,
  output logic                    last_result_o
);
  import tss_pkg::*;

  // Controller issues one datapath op per cycle and branches on status.
  cmd_t    cmd;
  status_t stat;

  tss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (stat),
    .cmd_o      (cmd)
  );

  // Datapath: forward sweep stores gamma and provisional u per row, then
  // walks them backward from the last row to row 0.
  tss_datapath #(.MaxRows(MaxRows)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (stat),
    .sub_diag_i    (sub_diag_i),
    .main_diag_i   (main_diag_i),
    .super_diag_i  (super_diag_i),
    .rhs_i         (rhs_i),
    .last_row_i    (last_row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .solution_o    (solution_o),
    .row_index_o   (row_index_o),
    .status_o_code (status_o),
    .last_result_o (last_result_o)
  );

endmodule

`default_nettype wire

[rtl/tss_checker.sv]
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks of the tridiagonal system solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tridiagonal_system_solver_macros.svh"

module tss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] solution_o,
  input wire logic [5:0]  row_index_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_result_o
);

  `TSS_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "out item dropped")
  `TSS_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                  "item accepted without busy")
  `TSS_ASSERT_IMP(a_err_shape, out_valid_o && (status_o != 2'd0),
                  last_result_o && (solution_o == 32'd0) && (row_index_o == 6'd0),
                  "error item malformed")
  `TSS_ASSERT_IMP(a_last_row0, out_valid_o && last_result_o, row_index_o == 6'd0,
                  "last item not row 0")

endmodule

bind tridiagonal_system_solver tss_checker u_tss_checker (.*);

`default_nettype wire
